FILE: hw/rtl/smc_pkg.sv
// Shared types and constants for the sprite mask collision block.
// Stands alone; the other files of the block, but for smc_stream_if, use it by scoped names.
package smc_pkg;

    localparam int IDX_W  = 10;
    localparam int PIX_W  = 32;
    localparam int POS_W  = 16;
    localparam int SIZE_W = 15;

    localparam logic [PIX_W-1:0] KEY_RESET = 32'd12599360;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                     cmd;
        logic [IDX_W-1:0]         pixel_index;
        logic [PIX_W-1:0]         pixel_value;
        logic signed [POS_W-1:0]  entity_x;
        logic signed [POS_W-1:0]  entity_y;
        logic [SIZE_W-1:0]        entity_w;
        logic [SIZE_W-1:0]        entity_h;
        logic signed [POS_W-1:0]  tile_x;
        logic signed [POS_W-1:0]  tile_y;
    } req_t;

    typedef struct packed {
        logic hit;
        logic overlap;
    } rsp_t;

    // Scan token handed from cell to cell.
    typedef struct packed {
        logic valid;
        logic hit;
    } token_t;

    // Pixel write broadcast to all cells.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             opaque;
    } wr_t;

endpackage

FILE: hw/rtl/smc_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
// Depends on nothing; the payload type is set per instance.
interface smc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/smc_cell.sv
// One mask row of the tile with its slot in the scan chain.
// Depends on smc_pkg.
module smc_cell #(
    parameter int TILE_SIZE = 32,
    parameter int ROW       = 0
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  smc_pkg::wr_t                       wr,
    input  logic [TILE_SIZE-1:0]               cols,
    input  logic [$clog2(TILE_SIZE+1)-1:0]     r0,
    input  logic [$clog2(TILE_SIZE+1)-1:0]     r1,
    input  smc_pkg::token_t                    tok_in,
    output smc_pkg::token_t                    tok_out
);

    localparam int RW    = $clog2(TILE_SIZE + 1);
    localparam int CW    = $clog2(TILE_SIZE);
    localparam int AW    = 14;
    localparam int BASE  = ROW * TILE_SIZE;
    localparam int LIMIT = BASE + TILE_SIZE;

    logic [TILE_SIZE-1:0] mask_reg;
    logic [TILE_SIZE-1:0] mask_next;
    smc_pkg::token_t      tok_reg;
    smc_pkg::token_t      tok_next;
    logic [AW-1:0]        idx_ext;
    logic [AW-1:0]        offset;
    logic [CW-1:0]        col;
    logic                 in_row;
    logic                 row_sel;

    assign idx_ext = AW'(wr.idx);
    assign in_row  = (idx_ext >= AW'(BASE)) && (idx_ext < AW'(LIMIT));
    assign offset  = idx_ext - AW'(BASE);
    assign col     = offset[CW-1:0];
    assign row_sel = (RW'(ROW) >= r0) && (RW'(ROW) < r1);

    always_comb
    begin
        mask_next = mask_reg;
        if (wr.en && in_row)
        begin
            mask_next[col] = wr.opaque;
        end
    end

    always_comb
    begin
        tok_next.valid = tok_in.valid;
        tok_next.hit   = tok_in.hit | (tok_in.valid & row_sel & (|(mask_reg & cols)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: hw/rtl/sprite_mask_collision_test.sv
// Sprite mask collision test: a load beat completes on acceptance and leaves the block ready.
// A query beat passes through the window calculation, the inject state, the row chain
// and the result capture, and the output register can hold it in ST_DONE while stalled;
// queries run one at a time, and the input stays not ready until the last one has left ST_DONE.
// Reset (rst_n, async low) clears the mask to transparent, sets the key colour to
// its default and drops any pending result.
module sprite_mask_collision_test #(
    parameter int TILE_SIZE = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    smc_stream_if.sink                      req,
    smc_stream_if.source                    rsp,
    input  logic                            cfg_we,
    input  logic [smc_pkg::PIX_W-1:0]       cfg_wdata
);

    localparam int RW = $clog2(TILE_SIZE + 1);
    localparam int EW = smc_pkg::POS_W + 2;   // room for edge plus size

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_INJECT,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [smc_pkg::PIX_W-1:0]       key_reg;

    // Query beat held for the window calculation.
    smc_pkg::req_t                   q_reg;

    // Overlap window in tile coordinates.
    logic                            ov_reg;
    logic [RW-1:0]                   c0_reg;
    logic [RW-1:0]                   c1_reg;
    logic [RW-1:0]                   r0_reg;
    logic [RW-1:0]                   r1_reg;

    logic                            res_hit_reg;
    logic                            out_valid_reg;
    smc_pkg::rsp_t                   out_data_reg;

    logic                            accept;
    smc_pkg::wr_t                    wr;
    logic [TILE_SIZE-1:0]            cols;
    smc_pkg::token_t                 tok [TILE_SIZE+1];

    logic signed [EW-1:0]            ex, ey, ew, eh, tx, ty;
    logic signed [EW-1:0]            ex2, ey2, tx2, ty2;
    logic signed [EW-1:0]            x1, y1, x2, y2;
    logic signed [EW-1:0]            c0_full, c1_full, r0_full, r1_full;
    logic                            ov_calc;

    // Input side: take beats only between queries; a load completes on its beat.
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    // Broadcast the pixel write; the owning cell picks it up by index range.
    assign wr.en     = accept && (req.data.cmd == smc_pkg::CMD_LOAD);
    assign wr.idx    = req.data.pixel_index;
    assign wr.opaque = (req.data.pixel_value != key_reg);

    // Intersect the entity rectangle with the tile square.
    always_comb
    begin
        ex  = EW'(q_reg.entity_x);
        ey  = EW'(q_reg.entity_y);
        ew  = $signed(EW'(q_reg.entity_w));
        eh  = $signed(EW'(q_reg.entity_h));
        tx  = EW'(q_reg.tile_x);
        ty  = EW'(q_reg.tile_y);
        ex2 = ex + ew;
        ey2 = ey + eh;
        tx2 = tx + $signed(EW'(TILE_SIZE));
        ty2 = ty + $signed(EW'(TILE_SIZE));
        x1  = (ex > tx) ? ex : tx;
        y1  = (ey > ty) ? ey : ty;
        x2  = (ex2 < tx2) ? ex2 : tx2;
        y2  = (ey2 < ty2) ? ey2 : ty2;
        ov_calc = (x2 > x1) && (y2 > y1);
        // With positive overlap these all land in 0..TILE_SIZE.
        c0_full = x1 - tx;
        c1_full = x2 - tx;
        r0_full = y1 - ty;
        r1_full = y2 - ty;
    end

    // Column mask of the window; empty when there is no overlap.
    always_comb
    begin
        for (int c = 0; c < TILE_SIZE; c++)
        begin
            cols[c] = ov_reg && (RW'(c) >= c0_reg) && (RW'(c) < c1_reg);
        end
    end

    // Row chain: the token enters row 0 and picks up a hit row by row.
    assign tok[0].valid = (state_reg == ST_INJECT);
    assign tok[0].hit   = 1'b0;

    for (genvar r = 0; r < TILE_SIZE; r++)
    begin : g_row
        smc_cell #(
            .TILE_SIZE (TILE_SIZE),
            .ROW       (r)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (wr),
            .cols    (cols),
            .r0      (r0_reg),
            .r1      (r1_reg),
            .tok_in  (tok[r]),
            .tok_out (tok[r+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.data.cmd == smc_pkg::CMD_QUERY))
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:   state_next = ST_INJECT;
            ST_INJECT: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (tok[TILE_SIZE].valid)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold the result until the output register frees up.
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_reg       <= smc_pkg::KEY_RESET;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                key_reg <= cfg_wdata;
            end
            if ((state_reg == ST_DONE) && (!out_valid_reg || rsp.ready))
            begin
                out_valid_reg        <= 1'b1;
                out_data_reg.hit     <= res_hit_reg;
                out_data_reg.overlap <= ov_reg;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg <= req.data;
        end
        if (state_reg == ST_CALC)
        begin
            ov_reg <= ov_calc;
            c0_reg <= c0_full[RW-1:0];
            c1_reg <= c1_full[RW-1:0];
            r0_reg <= r0_full[RW-1:0];
            r1_reg <= r1_full[RW-1:0];
        end
        if ((state_reg == ST_SCAN) && tok[TILE_SIZE].valid)
        begin
            res_hit_reg <= tok[TILE_SIZE].hit;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule

FILE: hw/rtl/smc_checker.sv
// Port-level checks for the sprite mask collision block, bound to its top level.
// Depends on smc_pkg and sprite_mask_collision_test.
module smc_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic req_cmd,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_hit,
    input logic rsp_overlap
);

    // A hit never comes without overlap.
    a_hit_needs_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!rsp_hit || rsp_overlap))
        else $error("hit reported without overlap");

    // A load beat leaves the block ready for the next beat.
    a_load_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req_cmd == smc_pkg::CMD_LOAD)) |=> req_ready)
        else $error("ready dropped after a load beat");

    // A query beat blocks the input while it scans.
    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req_cmd == smc_pkg::CMD_QUERY)) |=> !req_ready)
        else $error("input ready right after a query beat");

    // A stalled result holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_hit) && $stable(rsp_overlap)))
        else $error("stalled result changed");

endmodule

bind sprite_mask_collision_test smc_checker u_smc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_cmd     (req.data.cmd),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_hit     (rsp.data.hit),
    .rsp_overlap (rsp.data.overlap)
);

FILE: bench/sprite_mask_collision_test_checker.sv
// Checker for the sprite mask collision block: watches the request, response and
// key-colour ports, keeps its own mask and key, and counts mismatched results.
// Depends on smc_pkg for the beat types and widths.
module sprite_mask_collision_test_checker #(
    parameter int TILE_SIZE = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  logic                      req_ready,
    input  smc_pkg::req_t             req_data,
    input  logic                      rsp_valid,
    input  logic                      rsp_ready,
    input  smc_pkg::rsp_t             rsp_data,
    input  logic                      cfg_we,
    input  logic [smc_pkg::PIX_W-1:0] cfg_wdata,
    output int                        fail_count,
    output int                        results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [TILE_SIZE-1:0]      opaque_rows [TILE_SIZE];
    logic [smc_pkg::PIX_W-1:0] key_colour;
    smc_pkg::rsp_t             pending_results [$];
    smc_pkg::rsp_t             due;
    int                        mismatches;
    int                        row;
    int                        col;

    // Clip the entity against the tile square and look for an opaque pixel
    // inside the clipped window, in tile coordinates.
    function automatic smc_pkg::rsp_t predict_collision(smc_pkg::req_t q);
        int            ex, ey, ew, eh, tx, ty;
        int            x1, y1, x2, y2;
        smc_pkg::rsp_t r;
        ex = int'($signed(q.entity_x));
        ey = int'($signed(q.entity_y));
        ew = int'(q.entity_w);
        eh = int'(q.entity_h);
        tx = int'($signed(q.tile_x));
        ty = int'($signed(q.tile_y));
        x1 = (ex > tx) ? ex : tx;
        y1 = (ey > ty) ? ey : ty;
        x2 = (ex + ew < tx + TILE_SIZE) ? ex + ew : tx + TILE_SIZE;
        y2 = (ey + eh < ty + TILE_SIZE) ? ey + eh : ty + TILE_SIZE;
        r = '0;
        if (x2 > x1 && y2 > y1)
        begin
            r.overlap = 1'b1;
            for (int rr = y1 - ty; rr < y2 - ty; rr++)
                for (int cc = x1 - tx; cc < x2 - tx; cc++)
                    if (opaque_rows[rr][cc])
                        r.hit = 1'b1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TILE_SIZE; i++)
                opaque_rows[i] = '0;
            key_colour = smc_pkg::KEY_RESET;
            pending_results.delete();
            mismatches = 0;
            fail_count <= 0;
            results_due <= 0;
        end
        else
        begin
            // Responses first: a query accepted on this edge cannot answer yet.
            if (rsp_valid && rsp_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing due, got hit %0b overlap %0b",
                             $time, rsp_data.hit, rsp_data.overlap);
                    mismatches++;
                end
                else
                begin
                    due = pending_results.pop_front();
                    if (rsp_data.hit !== due.hit)
                    begin
                        $display("%0t: hit mismatch, expected %0b, got %0b",
                                 $time, due.hit, rsp_data.hit);
                        mismatches++;
                    end
                    if (rsp_data.overlap !== due.overlap)
                    begin
                        $display("%0t: overlap mismatch, expected %0b, got %0b",
                                 $time, due.overlap, rsp_data.overlap);
                        mismatches++;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                if (req_data.cmd == smc_pkg::CMD_LOAD)
                begin
                    row = int'(req_data.pixel_index) / TILE_SIZE;
                    col = int'(req_data.pixel_index) % TILE_SIZE;
                    if (row < TILE_SIZE)
                        opaque_rows[row][col] = (req_data.pixel_value != key_colour);
                end
                else
                begin
                    pending_results = {pending_results, predict_collision(req_data)};
                end
            end
            if (cfg_we)
                key_colour = cfg_wdata;
            fail_count <= mismatches;
            results_due <= pending_results.size();
        end
    end

endmodule

FILE: bench/sprite_mask_collision_test_test.sv
// Top of the sprite mask collision bench: clock, reset, request and response
// traffic, key-colour writes and the verdict. Depends on smc_pkg, smc_stream_if,
// the block itself and sprite_mask_collision_test_checker.
module sprite_mask_collision_test_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W  = smc_pkg::IDX_W;
    localparam int PIX_W  = smc_pkg::PIX_W;
    localparam int POS_W  = smc_pkg::POS_W;
    localparam int SIZE_W = smc_pkg::SIZE_W;

    localparam int TILE = 32;
    // Longest quiet stretch in a good run: one query through the row chain, the
    // settle before a key write, plus random receiver and sender stalls. Allow a
    // wide margin on top of that.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to let a trailing load or query finish before a key write or the end.
    localparam int SETTLE_CYCLES  = TILE + 8;
    localparam int PHASE_BEATS    = 477;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [PIX_W-1:0]   cfg_wdata;
    logic [PIX_W-1:0]   current_key;
    int                 send_idle = 28;
    int                 recv_idle = 76;
    int                 stall_cycles = 0;
    int                 fail_count;
    int                 results_due;

    smc_stream_if #(.payload_t(smc_pkg::req_t)) req_ch ();
    smc_stream_if #(.payload_t(smc_pkg::rsp_t)) rsp_ch ();

    sprite_mask_collision_test #(
        .TILE_SIZE (TILE)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    sprite_mask_collision_test_checker #(
        .TILE_SIZE (TILE)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_ch.valid),
        .req_ready   (req_ch.ready),
        .req_data    (req_ch.data),
        .rsp_valid   (rsp_ch.valid),
        .rsp_ready   (rsp_ch.ready),
        .rsp_data    (rsp_ch.data),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    always #2 clk = ~clk;

    // Result side: drop ready at random, at the rate the current phase asks.
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle);

    // Watchdog: any beat on either channel restarts the count.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Fill every field with random bits; the command picks which ones count.
    function automatic smc_pkg::req_t noise_beat();
        smc_pkg::req_t d;
        d.cmd         = 1'($urandom);
        d.pixel_index = IDX_W'($urandom);
        d.pixel_value = $urandom;
        d.entity_x    = POS_W'($urandom);
        d.entity_y    = POS_W'($urandom);
        d.entity_w    = SIZE_W'($urandom);
        d.entity_h    = SIZE_W'($urandom);
        d.tile_x      = POS_W'($urandom);
        d.tile_y      = POS_W'($urandom);
        return d;
    endfunction

    function automatic smc_pkg::req_t load_beat(logic [IDX_W-1:0] idx,
                                                logic [PIX_W-1:0] val);
        smc_pkg::req_t d;
        d = noise_beat();
        d.cmd         = smc_pkg::CMD_LOAD;
        d.pixel_index = idx;
        d.pixel_value = val;
        return d;
    endfunction

    // Coordinates wrap to the 16-bit fields; sizes to the 15-bit fields.
    function automatic smc_pkg::req_t query_beat(int ex, int ey, int ew, int eh,
                                                 int tx, int ty);
        smc_pkg::req_t d;
        d = noise_beat();
        d.cmd      = smc_pkg::CMD_QUERY;
        d.entity_x = POS_W'(ex);
        d.entity_y = POS_W'(ey);
        d.entity_w = SIZE_W'(ew);
        d.entity_h = SIZE_W'(eh);
        d.tile_x   = POS_W'(tx);
        d.tile_y   = POS_W'(ty);
        return d;
    endfunction

    function automatic int pick_origin();
        if ($urandom_range(3) == 0)
            return int'($signed(POS_W'($urandom)));
        return int'($urandom_range(2000)) - 1000;
    endfunction

    function automatic int pick_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45)
            return $urandom_range(8);
        if (roll < 90)
            return $urandom_range(48);
        return $urandom_range(32767);
    endfunction

    // Mostly loads that hit or miss the key, and queries placed around the tile
    // so the window lands on the mask; the rest is pure noise.
    function automatic smc_pkg::req_t random_beat();
        int roll;
        int tx, ty;
        roll = $urandom_range(99);
        if (roll < 40)
            return load_beat(IDX_W'($urandom), $urandom_range(1) ? current_key : $urandom);
        if (roll < 88)
        begin
            tx = pick_origin();
            ty = pick_origin();
            return query_beat(tx + int'($urandom_range(80)) - 40,
                              ty + int'($urandom_range(80)) - 40,
                              pick_size(), pick_size(), tx, ty);
        end
        return noise_beat();
    endfunction

    // Hold valid until the beat is taken; idle at random before raising it.
    task automatic push_beat(input smc_pkg::req_t d);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= d;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Drop valid and wait until every query has answered and any trailing
    // load or scan is done.
    task automatic settle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (results_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_key(input logic [PIX_W-1:0] val);
        settle();
        @(negedge clk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= val;
        current_key = val;
        @(negedge clk);
        cfg_we      <= 1'b0;
    endtask

    task automatic run_phase(input int sender_pct, input int receiver_pct, input int beats);
        send_idle = sender_pct;
        recv_idle = receiver_pct;
        repeat (beats) push_beat(random_beat());
    endtask

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        current_key  = smc_pkg::KEY_RESET;
        rst_n        = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, key at its reset value.
        // Fresh mask is all transparent: full overlap, no hit.
        push_beat(query_beat(0, 0, 32, 32, 0, 0));
        // Opaque corners, and a pixel equal to the key stays transparent.
        push_beat(load_beat(10'd0, 32'h0000_0000));
        push_beat(load_beat(10'd1023, 32'hFFFF_FFFF));
        push_beat(load_beat(10'd5, smc_pkg::KEY_RESET));
        push_beat(query_beat(0, 0, 32, 32, 0, 0));
        // Zero width, zero height: empty overlap.
        push_beat(query_beat(0, 0, 0, 32, 0, 0));
        push_beat(query_beat(0, 0, 32, 0, 0, 0));
        // Entity ends exactly at the tile's left edge and top edge.
        push_beat(query_beat(-10, 0, 10, 32, 0, 0));
        push_beat(query_beat(0, -10, 32, 10, 0, 0));
        // Single pixels: far corner opaque, key-coloured pixel transparent.
        push_beat(query_beat(131, -69, 1, 1, 100, -100));
        push_beat(query_beat(105, -100, 1, 1, 100, -100));
        // Coordinate extremes, negative and positive.
        push_beat(query_beat(-32768, -32768, 32767, 32767, -32768, -32768));
        push_beat(query_beat(32767, 32767, 32767, 32767, 32767, 32767));
        push_beat(query_beat(-32768, -32768, 32767, 32767, -10, -10));
        // Entity wholly inside the tile, away from opaque pixels.
        push_beat(query_beat(8, 8, 16, 16, 0, 0));
        // Clear the corners again with the key, then check.
        push_beat(load_beat(10'd0, smc_pkg::KEY_RESET));
        push_beat(load_beat(10'd1023, smc_pkg::KEY_RESET));
        push_beat(query_beat(0, 0, 1, 1, 0, 0));
        push_beat(query_beat(-5, -5, 100, 100, 0, 0));

        // Random part: three idling mixes, a new key before each.
        write_key(32'hFFFF_FFFF);
        run_phase(28, 76, PHASE_BEATS);
        write_key(32'h0000_0000);
        run_phase(76, 28, PHASE_BEATS);
        write_key($urandom);
        run_phase(0, 0, PHASE_BEATS);

        settle();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
